// ===== rtl/core/assert_macros.svh =====
// shared assertion shorthands, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/scl_pkg.sv =====
package scl_pkg;

    localparam int POS_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    // token slots per queue word: byte flush, byte token, end flush, end token
    localparam int SLOTS           = 4;
    localparam int NUM_W           = 31;
    localparam logic [NUM_W-1:0] NUM_MAX = '1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_US     = "_";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_COLON  = ":";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_9      = "9";
    localparam logic [7:0] CH_UA     = "A";
    localparam logic [7:0] CH_UZ     = "Z";
    localparam logic [7:0] CH_LA     = "a";
    localparam logic [7:0] CH_LZ     = "z";
    localparam logic [7:0] CH_E      = "e";
    localparam logic [7:0] CH_F      = "f";
    localparam logic [7:0] CH_N      = "n";
    localparam logic [7:0] CH_R      = "r";
    localparam logic [7:0] CH_T      = "t";
    localparam logic [7:0] CH_U      = "u";

    typedef enum logic [3:0] {
        KIND_END    = 4'd0,
        KIND_FN     = 4'd1,
        KIND_IDENT  = 4'd2,
        KIND_NUMBER = 4'd3,
        KIND_LPAREN = 4'd4,
        KIND_RPAREN = 4'd5,
        KIND_LBRACE = 4'd6,
        KIND_RBRACE = 4'd7,
        KIND_RETURN = 4'd8,
        KIND_COLON  = 4'd9,
        KIND_ARROW  = 4'd10,
        KIND_COMMA  = 4'd11,
        KIND_SEMI   = 4'd12,
        KIND_PLUS   = 4'd13,
        KIND_ERROR  = 4'd14
    } tok_kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_IDENT   = 5'b00010,
        MODE_NUMBER  = 5'b00100,
        MODE_MINUS   = 5'b01000,
        MODE_DISCARD = 5'b10000
    } mode_t;

    // keyword prefix tracker
    typedef enum logic [9:0] {
        KW_NONE   = 10'b0000000001,
        KW_F      = 10'b0000000010,
        KW_FN     = 10'b0000000100,
        KW_R      = 10'b0000001000,
        KW_RE     = 10'b0000010000,
        KW_RET    = 10'b0000100000,
        KW_RETU   = 10'b0001000000,
        KW_RETUR  = 10'b0010000000,
        KW_RETURN = 10'b0100000000,
        KW_DEAD   = 10'b1000000000
    } kw_t;

    typedef struct packed {
        tok_kind_t        kind;
        logic [NUM_W-1:0] value;
        logic             overflow;
        logic             eor;
    } tok_info_t;

    localparam int INFO_W = $bits(tok_info_t);

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic int entry_bits(input int pos_bits);
        return SLOTS * (INFO_W + 2 * pos_bits) + SLOTS;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // single-byte tokens; anything else maps to error
    function automatic tok_kind_t punct_kind(input logic [7:0] c);
        tok_kind_t k;
        case (c)
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_COLON:  k = KIND_COLON;
            CH_COMMA:  k = KIND_COMMA;
            CH_SEMI:   k = KIND_SEMI;
            CH_PLUS:   k = KIND_PLUS;
            default:   k = KIND_ERROR;
        endcase
        return k;
    endfunction

    function automatic kw_t kw_step(input kw_t kp, input logic [7:0] c);
        kw_t n;
        n = KW_DEAD;
        case (kp)
            KW_NONE:  n = (c == CH_F) ? KW_F : ((c == CH_R) ? KW_R : KW_DEAD);
            KW_F:     n = (c == CH_N) ? KW_FN : KW_DEAD;
            KW_R:     n = (c == CH_E) ? KW_RE : KW_DEAD;
            KW_RE:    n = (c == CH_T) ? KW_RET : KW_DEAD;
            KW_RET:   n = (c == CH_U) ? KW_RETU : KW_DEAD;
            KW_RETU:  n = (c == CH_R) ? KW_RETUR : KW_DEAD;
            KW_RETUR: n = (c == CH_N) ? KW_RETURN : KW_DEAD;
            default:  n = KW_DEAD;
        endcase
        return n;
    endfunction

    function automatic tok_kind_t ident_kind(input kw_t kp);
        tok_kind_t k;
        case (kp)
            KW_FN:     k = KIND_FN;
            KW_RETURN: k = KIND_RETURN;
            default:   k = KIND_IDENT;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/scl_front.sv =====
`include "assert_macros.svh"

module scl_front #(
    parameter int POS_BITS = scl_pkg::POS_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic [7:0]                                 ch,
    input  logic                                       has_char,
    input  logic                                       last,
    input  logic                                       push,
    input  scl_pkg::q_status_t                         q_stat,
    output logic                                       wr_en,
    output logic [scl_pkg::entry_bits(POS_BITS)-1:0]   wr_data
);

    typedef struct packed {
        scl_pkg::tok_info_t  info;
        logic [POS_BITS-1:0] start;
        logic [POS_BITS-1:0] length;
    } tok_t;

    typedef struct packed {
        logic [scl_pkg::SLOTS-1:0] valid;
        tok_t [scl_pkg::SLOTS-1:0] tok;
    } entry_t;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
    localparam logic [POS_BITS-1:0] POS_TWO = POS_BITS'(2);
    localparam int SUM_W = scl_pkg::NUM_W + 4;

    // slot order inside one word
    localparam int SLOT_FLUSH     = 0;
    localparam int SLOT_BYTE      = 1;
    localparam int SLOT_END_FLUSH = 2;
    localparam int SLOT_END       = 3;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + POS_ONE;
    endfunction

    function automatic tok_t mk_tok(
        input scl_pkg::tok_kind_t          kind,
        input logic [POS_BITS-1:0]         start,
        input logic [POS_BITS-1:0]         length,
        input logic [scl_pkg::NUM_W-1:0]   value,
        input logic                        ovf,
        input logic                        eor
    );
        tok_t t;
        t.info.kind     = kind;
        t.info.value    = value;
        t.info.overflow = ovf;
        t.info.eor      = eor;
        t.start         = start;
        t.length        = length;
        return t;
    endfunction

    scl_pkg::mode_t              mode_reg, mode_next;
    scl_pkg::kw_t                kw_reg, kw_next;
    logic [POS_BITS-1:0]         start_reg, start_next;
    logic [POS_BITS-1:0]         len_reg, len_next;
    logic [scl_pkg::NUM_W-1:0]   acc_reg, acc_next;
    logic                        ovf_reg, ovf_next;
    logic [POS_BITS-1:0]         pos_reg, pos_next;

    entry_t                      ent;
    logic                        fire;
    logic                        do_idle;
    logic [3:0]                  digit;
    logic [SUM_W-1:0]            num_sum;
    logic                        num_sat;
    logic                        ident_cont;
    scl_pkg::tok_kind_t          byte_kind;

    assign fire       = push && !q_stat.full;
    assign digit      = ch[3:0];
    // acc * 10 + digit as two shifts and adds
    assign num_sum    = {3'b000, acc_reg, 1'b0} + {1'b0, acc_reg, 3'b000}
                      + SUM_W'(digit);
    assign num_sat    = num_sum > SUM_W'(scl_pkg::NUM_MAX);
    assign ident_cont = scl_pkg::is_alpha(ch) || scl_pkg::is_digit(ch) || (ch == scl_pkg::CH_US);
    assign byte_kind  = scl_pkg::punct_kind(ch);

    always_comb
    begin
        mode_next  = mode_reg;
        kw_next    = kw_reg;
        start_next = start_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        ent        = '0;
        do_idle    = 1'b0;

        if (has_char)
        begin
            pos_next = sat_inc(pos_reg);
            case (mode_reg)
                scl_pkg::MODE_MINUS:
                begin
                    ent.valid[SLOT_FLUSH] = 1'b1;
                    if (ch == scl_pkg::CH_GT)
                    begin
                        ent.tok[SLOT_FLUSH] = mk_tok(scl_pkg::KIND_ARROW, start_reg, POS_TWO,
                                                     '0, 1'b0, 1'b0);
                        mode_next = scl_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        // lone minus, the rest of the source up to last is dropped
                        ent.tok[SLOT_FLUSH] = mk_tok(scl_pkg::KIND_ERROR, start_reg, POS_ONE,
                                                     '0, 1'b0, 1'b0);
                        mode_next = scl_pkg::MODE_DISCARD;
                    end
                end
                scl_pkg::MODE_IDENT:
                begin
                    if (ident_cont)
                    begin
                        len_next = sat_inc(len_reg);
                        kw_next  = scl_pkg::kw_step(kw_reg, ch);
                    end
                    else
                    begin
                        ent.valid[SLOT_FLUSH] = 1'b1;
                        ent.tok[SLOT_FLUSH]   = mk_tok(scl_pkg::ident_kind(kw_reg), start_reg,
                                                       len_reg, '0, 1'b0, 1'b0);
                        do_idle = 1'b1;
                    end
                end
                scl_pkg::MODE_NUMBER:
                begin
                    if (scl_pkg::is_digit(ch))
                    begin
                        len_next = sat_inc(len_reg);
                        if (num_sat)
                        begin
                            acc_next = scl_pkg::NUM_MAX;
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = num_sum[scl_pkg::NUM_W-1:0];
                        end
                    end
                    else
                    begin
                        ent.valid[SLOT_FLUSH] = 1'b1;
                        ent.tok[SLOT_FLUSH]   = mk_tok(scl_pkg::KIND_NUMBER, start_reg, len_reg,
                                                       acc_reg, ovf_reg, 1'b0);
                        do_idle = 1'b1;
                    end
                end
                scl_pkg::MODE_IDLE:
                begin
                    do_idle = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (do_idle)
            begin
                mode_next = scl_pkg::MODE_IDLE;
                if (ch == scl_pkg::CH_NUL)
                begin
                    mode_next = scl_pkg::MODE_DISCARD;
                end
                else if (scl_pkg::is_space(ch))
                begin
                end
                else if (scl_pkg::is_alpha(ch))
                begin
                    mode_next  = scl_pkg::MODE_IDENT;
                    start_next = pos_reg;
                    len_next   = POS_ONE;
                    kw_next    = scl_pkg::kw_step(scl_pkg::KW_NONE, ch);
                end
                else if (scl_pkg::is_digit(ch))
                begin
                    mode_next  = scl_pkg::MODE_NUMBER;
                    start_next = pos_reg;
                    len_next   = POS_ONE;
                    acc_next   = scl_pkg::NUM_W'(digit);
                    ovf_next   = 1'b0;
                end
                else if (ch == scl_pkg::CH_MINUS)
                begin
                    mode_next  = scl_pkg::MODE_MINUS;
                    start_next = pos_reg;
                    len_next   = POS_ONE;
                end
                else
                begin
                    ent.valid[SLOT_BYTE] = 1'b1;
                    ent.tok[SLOT_BYTE]   = mk_tok(byte_kind, pos_reg, POS_ONE, '0, 1'b0, 1'b0);
                    if (byte_kind == scl_pkg::KIND_ERROR)
                    begin
                        mode_next = scl_pkg::MODE_DISCARD;
                    end
                end
            end
        end

        if (last)
        begin
            case (mode_next)
                scl_pkg::MODE_IDENT:
                begin
                    ent.valid[SLOT_END_FLUSH] = 1'b1;
                    ent.tok[SLOT_END_FLUSH]   = mk_tok(scl_pkg::ident_kind(kw_next), start_next,
                                                       len_next, '0, 1'b0, 1'b0);
                end
                scl_pkg::MODE_NUMBER:
                begin
                    ent.valid[SLOT_END_FLUSH] = 1'b1;
                    ent.tok[SLOT_END_FLUSH]   = mk_tok(scl_pkg::KIND_NUMBER, start_next,
                                                       len_next, acc_next, ovf_next, 1'b0);
                end
                scl_pkg::MODE_MINUS:
                begin
                    ent.valid[SLOT_END_FLUSH] = 1'b1;
                    ent.tok[SLOT_END_FLUSH]   = mk_tok(scl_pkg::KIND_ERROR, start_next, POS_ONE,
                                                       '0, 1'b0, 1'b0);
                end
                default:
                begin
                end
            endcase
            ent.valid[SLOT_END] = 1'b1;
            ent.tok[SLOT_END]   = mk_tok(scl_pkg::KIND_END, pos_next, '0, '0, 1'b0, 1'b1);

            // back to the reset state for the next source
            mode_next  = scl_pkg::MODE_IDLE;
            kw_next    = scl_pkg::KW_NONE;
            start_next = '0;
            len_next   = '0;
            acc_next   = '0;
            ovf_next   = 1'b0;
            pos_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= scl_pkg::MODE_IDLE;
            kw_reg    <= scl_pkg::KW_NONE;
            start_reg <= '0;
            len_reg   <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            kw_reg    <= kw_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            pos_reg   <= pos_next;
        end
    end

    assign wr_en   = fire && (ent.valid != '0);
    assign wr_data = ent;

    `ASSERT_NEXT(a_front_end_resets, fire && last,
                 (mode_reg == scl_pkg::MODE_IDLE) && (pos_reg == '0),
                 "front state not cleared after end of source")

endmodule

// ===== rtl/core/scl_queue.sv =====
`include "assert_macros.svh"

module scl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = scl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [WIDTH-1:0]   wr_data,
    input  logic               rd_en,
    output logic [WIDTH-1:0]   rd_data,
    output scl_pkg::q_status_t q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign wr_ptr_next = wr_en ? ((wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1))
                               : wr_ptr_reg;
    assign rd_ptr_next = rd_en ? ((rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1))
                               : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data      = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);

    `ASSERT_IMPL(a_queue_no_overrun, wr_en, count_reg != CNT_FULL,
                 "write into full token queue")
    `ASSERT_IMPL(a_queue_no_underrun, rd_en, count_reg != '0,
                 "read from empty token queue")

endmodule

// ===== rtl/core/scl_back.sv =====
`include "assert_macros.svh"

module scl_back #(
    parameter int POS_BITS = scl_pkg::POS_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [scl_pkg::entry_bits(POS_BITS)-1:0] rd_data,
    input  scl_pkg::q_status_t                       q_stat,
    output logic                                     rd_en,
    input  logic                                     pop,
    output logic                                     empty,
    output logic [3:0]                               token_kind,
    output logic [POS_BITS-1:0]                      token_start,
    output logic [POS_BITS-1:0]                      token_length,
    output logic [scl_pkg::NUM_W-1:0]                number_value,
    output logic                                     number_overflow,
    output logic                                     end_of_run
);

    typedef struct packed {
        scl_pkg::tok_info_t  info;
        logic [POS_BITS-1:0] start;
        logic [POS_BITS-1:0] length;
    } tok_t;

    typedef struct packed {
        logic [scl_pkg::SLOTS-1:0] valid;
        tok_t [scl_pkg::SLOTS-1:0] tok;
    } entry_t;

    localparam int SEL_W = $clog2(scl_pkg::SLOTS);

    entry_t                     head;
    logic [scl_pkg::SLOTS-1:0]  done_reg, done_next;
    logic [scl_pkg::SLOTS-1:0]  remaining;
    logic [scl_pkg::SLOTS-1:0]  sel_mask;
    logic [SEL_W-1:0]           sel;
    logic                       last_slot;
    logic                       load;
    logic                       out_valid_reg, out_valid_next;
    tok_t                       out_tok_reg;

    assign head      = rd_data;
    assign remaining = head.valid & ~done_reg;

    // lowest remaining slot goes out first
    always_comb
    begin
        sel = '0;
        for (int i = scl_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (remaining[i])
            begin
                sel = SEL_W'(i);
            end
        end
    end

    assign sel_mask  = scl_pkg::SLOTS'(1) << sel;
    assign last_slot = (remaining & ~sel_mask) == '0;
    assign load      = !q_stat.empty && (!out_valid_reg || pop);
    assign rd_en     = load && last_slot;

    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            done_next      = rd_en ? '0 : (done_reg | sel_mask);
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_tok_reg <= head.tok[sel];
        end
    end

    assign empty           = !out_valid_reg;
    assign token_kind      = out_tok_reg.info.kind;
    assign token_start     = out_tok_reg.start;
    assign token_length    = out_tok_reg.length;
    assign number_value    = out_tok_reg.info.value;
    assign number_overflow = out_tok_reg.info.overflow;
    assign end_of_run      = out_tok_reg.info.eor;

    `ASSERT_IMPL(a_back_head_has_work, !q_stat.empty, remaining != '0,
                 "queued word has no token left to send")
    `ASSERT_IMPL(a_back_partial_at_head, done_reg != '0, !q_stat.empty,
                 "partly sent word left the queue")

endmodule

// ===== rtl/core/source_char_lexer_top.sv =====
// source_char_lexer_top: streaming tokenizer, one source byte per input word.
// Both sides look like a queue: push a byte word while full is low, pop a token
// word while empty is low. A byte is taken every cycle as long as the token
// queue between the lexer front and the output stage has room, so a source
// streams at one byte per clock. Each byte word yields zero to three token
// words (a closing word with last set always ends with an end token); the
// output stage hands out one token word per cycle while pop keeps its output
// register free, so a byte that yields several tokens holds the output until
// each has gone out, and the sustained rate is one byte per cycle whenever
// tokens average no more than one per byte. A token completed by an accepted
// byte is written into the token queue, then loaded into the output register
// where it can be popped, later when older tokens are still waiting.
// QUEUE_DEPTH words of buffering (at least 2) absorb bursts and output stalls;
// POS_BITS (8 to 32) sets the width of positions and lengths, which saturate
// at all ones. There is no configuration and no clearing pass after reset.

module source_char_lexer_top #(
    parameter int POS_BITS    = scl_pkg::POS_BITS_DEF,
    parameter int QUEUE_DEPTH = scl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // byte side
    input  logic [7:0]                ch,
    input  logic                      has_char,
    input  logic                      last,
    input  logic                      push,
    output logic                      full,
    // token side
    output logic [3:0]                token_kind,
    output logic [POS_BITS-1:0]       token_start,
    output logic [POS_BITS-1:0]       token_length,
    output logic [scl_pkg::NUM_W-1:0] number_value,
    output logic                      number_overflow,
    output logic                      end_of_run,
    output logic                      empty,
    input  logic                      pop
);

    // one queue word carries every token a single byte word can produce
    localparam int ENTRY_W = scl_pkg::entry_bits(POS_BITS);

    scl_pkg::q_status_t   q_stat;
    logic                 q_wr_en;
    logic [ENTRY_W-1:0]   q_wr_data;
    logic                 q_rd_en;
    logic [ENTRY_W-1:0]   q_rd_data;

    // full back-pressure comes straight from the token queue
    assign full = q_stat.full;

    // front: classifies the byte, runs the lexer state, builds token words
    scl_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .ch       (ch),
        .has_char (has_char),
        .last     (last),
        .push     (push),
        .q_stat   (q_stat),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data)
    );

    // decoupling queue between lexer and output stage
    scl_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .q_stat  (q_stat)
    );

    // back: splits each word into single tokens behind an output register
    scl_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .rd_data         (q_rd_data),
        .q_stat          (q_stat),
        .rd_en           (q_rd_en),
        .pop             (pop),
        .empty           (empty),
        .token_kind      (token_kind),
        .token_start     (token_start),
        .token_length    (token_length),
        .number_value    (number_value),
        .number_overflow (number_overflow),
        .end_of_run      (end_of_run)
    );

endmodule
